/* rtl/bced_pkg.sv */
`timescale 1ns / 1ps

package bced_pkg;

   // Longest row that the line memory holds.
   localparam int MAX_WIDTH  = 2048;
   // Tallest frame that the row counter follows.
   localparam int MAX_HEIGHT = 2048;
   localparam int MIN_DIM    = 3;

   // Column address into the line memory.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   // Width of the frame size registers and of the row counter.
   localparam int DIM_W  = 12;
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] REG_MODE   = 2'd0;
   localparam logic [CSR_IW-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_HEIGHT = 2'd2;

   localparam logic MODE_ERODE  = 1'b0;
   localparam logic MODE_DILATE = 1'b1;

   // One line memory entry: bit 1 is the row two above, bit 0 the row above.
   typedef logic [1:0] line_entry_type;

   typedef struct packed {
      logic           en;
      logic [COL_W-1:0] addr;
      line_entry_type data;
   } line_wr_type;

endpackage

/* rtl/bced_line_mem.sv */
`timescale 1ns / 1ps

module bced_line_mem (
   input  logic                         clock,
   input  bced_pkg::line_wr_type        wr,
   input  logic [bced_pkg::COL_W-1:0]   rd_addr,
   output bced_pkg::line_entry_type     rd_data
);

   bced_pkg::line_entry_type mem [bced_pkg::MAX_WIDTH];
   bced_pkg::line_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read every cycle; a write to the same address in the same cycle returns the old entry.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/binary_cross_erode_dilate.sv */
`timescale 1ns / 1ps
// Binary erosion and dilation with a five-pixel plus shape over a raster pixel stream.
// Requests arrive on the req_ channel (valid/ready), one pixel each in raster order;
// every accepted request produces exactly one response on the rsp_ channel. The
// response for a request describes the pixel one row and one column behind it;
// rsp_valid_out is low for the whole first row and for the first request of the second.
// After the frame's last pixel the host sends frame_width + 1 flush requests to drain
// the final row, and the last of these carries rsp_last_out. A flush sent mid-frame is
// ignored and answered with an all-zero response.
// Throughput is one request per clock while responses are taken: the line memory is read
// ahead, at the address of the next column, so its registered read never stalls the
// stream. A response appears in the output register the cycle after its request is
// accepted; a new request is still taken while that register is being emptied.
// When the receiver stalls, the held response blocks req_ready until it is taken.
// Reset clears the position, window and configuration (erode, 2048 x 2048); the line
// memory is not cleared, as rows above the frame are masked to zero. Writing
// frame_width or frame_height restarts the frame; mode takes effect at once.
module binary_cross_erode_dilate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_pixel_in,
   input  logic                          req_flush,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pixel_out,
   output logic                          rsp_valid_out,
   output logic                          rsp_last_out,
   input  logic                          csr_we,
   input  logic [bced_pkg::CSR_IW-1:0]   csr_index,
   input  logic [bced_pkg::DIM_W-1:0]    csr_wdata
);

   // Configuration registers.
   logic                           mode_ff;
   logic [bced_pkg::DIM_W-1:0]     width_ff;
   logic [bced_pkg::DIM_W-1:0]     height_ff;

   // Frame position and the two previous columns of the three-row window.
   logic [bced_pkg::COL_W-1:0]     col_ff, col_in;
   logic [bced_pkg::DIM_W-1:0]     row_ff, row_in;
   logic [5:0]                     window_ff, window_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_pixel_ff, rsp_pixel_in;
   logic                           rsp_vout_ff, rsp_vout_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           cfg_restart;
   logic [bced_pkg::COL_W-1:0]     width_last;
   logic [bced_pkg::DIM_W-1:0]     height_eff;
   logic [bced_pkg::DIM_W-1:0]     height_plus1;

   bced_pkg::line_wr_type          line_wr;
   bced_pkg::line_entry_type       line_rd;
   logic [bced_pkg::COL_W-1:0]     line_rd_addr;

   logic                           in_frame;
   logic                           drop;
   logic                           pix;
   logic                           above;
   logic                           above2;
   logic                           top, mid, bot, left, right;
   logic                           res;
   logic                           item_valid;
   logic                           item_last;
   logic                           row_end;

   assign accept      = req_valid && req_ready;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign cfg_restart = csr_we && (csr_index == bced_pkg::REG_WIDTH ||
                                   csr_index == bced_pkg::REG_HEIGHT);

   // Frame sizes clamped to their legal ranges; the width is kept as its last column.
   always_comb begin
      if (width_ff < bced_pkg::DIM_W'(bced_pkg::MIN_DIM)) begin
         width_last = bced_pkg::COL_W'(bced_pkg::MIN_DIM - 1);
      end else if (32'(width_ff) > 32'(bced_pkg::MAX_WIDTH)) begin
         width_last = bced_pkg::COL_W'(bced_pkg::MAX_WIDTH - 1);
      end else begin
         width_last = bced_pkg::COL_W'(width_ff - bced_pkg::DIM_W'(1));
      end
      if (height_ff < bced_pkg::DIM_W'(bced_pkg::MIN_DIM)) begin
         height_eff = bced_pkg::DIM_W'(bced_pkg::MIN_DIM);
      end else if (32'(height_ff) > 32'(bced_pkg::MAX_HEIGHT)) begin
         height_eff = bced_pkg::DIM_W'(bced_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
      height_plus1 = height_eff + bced_pkg::DIM_W'(1);
   end

   // Work on the request at the current position. The line memory already holds the
   // entry for this column in line_rd, fetched in the cycle before.
   always_comb begin
      in_frame = row_ff < height_eff;
      drop     = in_frame && req_flush;
      pix      = in_frame && req_pixel_in;
      // Rows above the top of the frame and the drain row below it read as zero.
      above    = (row_ff != '0) && (row_ff <= height_eff) && line_rd[0];
      above2   = (row_ff > bced_pkg::DIM_W'(1)) && (row_ff <= height_eff) && line_rd[1];

      // The window centre is the column before the current one.
      top   = window_ff[0];
      mid   = window_ff[1];
      bot   = window_ff[2];
      left  = (col_ff == bced_pkg::COL_W'(1)) ? 1'b0 : window_ff[4];
      right = (col_ff != '0) && above;

      if (mode_ff == bced_pkg::MODE_DILATE) begin
         res = top | mid | bot | left | right;
      end else begin
         res = top & mid & bot & left & right;
      end

      item_valid = ((col_ff != '0) && (row_ff != '0)) ||
                   ((col_ff == '0) && (row_ff > bced_pkg::DIM_W'(1)));
      item_last  = row_ff == height_plus1;
      row_end    = col_ff == width_last;

      line_wr.en   = accept && !drop && (row_ff <= height_eff);
      line_wr.addr = col_ff;
      line_wr.data = {above, pix};

      // Advance the position; a mid-frame flush leaves everything as it was.
      col_in    = col_ff;
      row_in    = row_ff;
      window_in = window_ff;
      if (cfg_restart) begin
         col_in    = '0;
         row_in    = '0;
         window_in = '0;
      end else if (accept && !drop) begin
         if (item_last) begin
            col_in    = '0;
            row_in    = '0;
            window_in = '0;
         end else begin
            window_in = {window_ff[2:0], pix, above, above2};
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + bced_pkg::DIM_W'(1);
            end else begin
               col_in = col_ff + bced_pkg::COL_W'(1);
            end
         end
      end

      // Fetch the entry for the column the next request will use.
      line_rd_addr = col_in;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_vout_in  = rsp_vout_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = !drop && item_valid && res;
         rsp_vout_in  = !drop && item_valid;
         rsp_last_in  = !drop && item_valid && item_last;
      end
   end

   bced_line_mem u_line_mem (
      .clock   (clock),
      .wr      (line_wr),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bced_pkg::MODE_ERODE;
         width_ff  <= bced_pkg::DIM_W'(bced_pkg::MAX_WIDTH);
         height_ff <= bced_pkg::DIM_W'(bced_pkg::MAX_HEIGHT);
      end else if (csr_we) begin
         case (csr_index)
            bced_pkg::REG_MODE:   mode_ff   <= csr_wdata[0];
            bced_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            bced_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_vout_ff  <= rsp_vout_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_valid_out = rsp_vout_ff;
   assign rsp_last_out  = rsp_last_ff;

   // The column never runs past the last column of the row.
   a_col_bound : assert property (@(posedge clock) disable iff (reset)
      col_ff <= width_last)
      else $error("column position beyond the row");

   // The row never runs past the drain row.
   a_row_bound : assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_plus1)
      else $error("row position beyond the drain row");

   // The request that ends the frame puts the position back to the origin.
   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      accept && !drop && item_last && !cfg_restart |=> col_ff == '0 && row_ff == '0)
      else $error("frame did not restart after its last pixel");

   // A response that is held back is never overwritten by a new request.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_pixel_ff) &&
                                     $stable(rsp_last_ff))
      else $error("held response was overwritten");

endmodule

/* tb/tb_binary_cross_erode_dilate.sv */
`timescale 1ns / 1ps

// Self-checking bench for the plus-shaped binary erode/dilate filter.
// Requests are driven on the falling edge from a queue that the stimulus process
// fills. Handshakes are sampled on the rising edge. Every accepted request is run
// through a local copy of the filter, and the predicted response is queued. The
// check then takes the oldest prediction for each response and compares it with
// what the block returned.
module tb_binary_cross_erode_dilate;

   // Index 3 names no register. A write to it must leave the filter untouched.
   localparam logic [bced_pkg::CSR_IW-1:0] REG_UNUSED = 2'd3;
   // Random requests that count towards the stopping point. Ignored flushes do not count.
   localparam int RANDOM_PIXELS = 1250;
   // The block takes one request per clock while responses are taken. Even with both
   // sides idling, a correct run keeps making handshakes, so a limit this high
   // can only be reached by a hang.
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic pixel;
      logic flush;
   } pixel_req_type;

   typedef struct packed {
      logic pixel_out;
      logic valid_out;
      logic last_out;
   } filtered_type;

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_ready;
   logic                           req_pixel_in = 1'b0;
   logic                           req_flush    = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready    = 1'b0;
   logic                           rsp_pixel_out;
   logic                           rsp_valid_out;
   logic                           rsp_last_out;
   logic                           csr_we       = 1'b0;
   logic [bced_pkg::CSR_IW-1:0]    csr_index    = bced_pkg::REG_MODE;
   logic [bced_pkg::DIM_W-1:0]     csr_wdata    = '0;

   binary_cross_erode_dilate dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_in  (req_pixel_in),
      .req_flush     (req_flush),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_valid_out (rsp_valid_out),
      .rsp_last_out  (rsp_last_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pixel_req_type queued_pixels[$];   // requests waiting to be presented
   filtered_type  filtered_due[$];    // predicted responses, oldest first
   bit            req_taken   = 1'b0; // set on the edge that accepts the request on the port
   bit            sender_idle = 1'b1; // nothing presented and nothing queued
   bit            idling      = 1'b1; // random gaps on both channels
   bit            failed      = 1'b0;
   int            quiet_cycles = 0;

   // Local copy of the filter state. It starts from the reset configuration:
   // erode, 2048 x 2048.
   logic                       mode_sel   = bced_pkg::MODE_ERODE;
   logic [bced_pkg::DIM_W-1:0] width_reg  = bced_pkg::DIM_W'(bced_pkg::MAX_WIDTH);
   logic [bced_pkg::DIM_W-1:0] height_reg = bced_pkg::DIM_W'(bced_pkg::MAX_HEIGHT);
   bit                         line_above [bced_pkg::MAX_WIDTH];
   bit                         line_two_above [bced_pkg::MAX_WIDTH];
   logic [8:0]                 window  = '0;
   int                         row_pos = 0;
   int                         col_pos = 0;

   function automatic int clamp_dim(logic [bced_pkg::DIM_W-1:0] value, int hi);
      if (value < bced_pkg::MIN_DIM) return bced_pkg::MIN_DIM;
      if (value > hi) return hi;
      return value;
   endfunction

   function automatic void restart_frame();
      window  = '0;
      row_pos = 0;
      col_pos = 0;
   endfunction

   // Advances the local filter by one request and returns the response that it should give.
   function automatic filtered_type predict_filtered(logic pin, logic fl);
      int           w, h;
      logic         pix, above, two_above, top, mid, bot, left, right, hit;
      filtered_type res;
      w = clamp_dim(width_reg, bced_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bced_pkg::MAX_HEIGHT);
      res = '0;
      if (col_pos >= w || row_pos > h + 1) restart_frame();
      // A flush that arrives while frame pixels are still due is dropped.
      // The position does not move, and the response is all zero.
      if (row_pos < h && fl) return res;
      // Once the whole frame is in, every request drains and its pixel is ignored.
      pix = (row_pos < h) ? pin : 1'b0;
      above = 1'b0;
      two_above = 1'b0;
      if (row_pos <= h) begin
         // Rows above the top of the frame read as zero padding.
         if (row_pos >= 1) above = line_above[col_pos];
         if (row_pos >= 2) two_above = line_two_above[col_pos];
         line_two_above[col_pos] = above;
         line_above[col_pos] = pix;
      end
      // The centre column of the window is the one taken on the previous request.
      top = window[0];
      mid = window[1];
      bot = window[2];
      if (col_pos >= 1) begin
         left  = (col_pos >= 2) ? window[4] : 1'b0;
         right = above;
      end else begin
         // The centre is the last column of a row, so the right neighbour is padding.
         left  = window[4];
         right = 1'b0;
      end
      hit = (mode_sel == bced_pkg::MODE_DILATE) ? (top | mid | bot | left | right)
                                                : (top & mid & bot & left & right);
      if ((col_pos >= 1 && row_pos >= 1) || (col_pos == 0 && row_pos >= 2)) begin
         res.pixel_out = hit;
         res.valid_out = 1'b1;
         res.last_out  = (row_pos == h + 1);
      end
      window = {window[5:0], pix, above, two_above};
      if (row_pos == h + 1) begin
         restart_frame();
      end else begin
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // Request driver. A presented request is held until it is accepted. The next one
   // may follow on the very next cycle, so a back-to-back stream keeps valid high.
   always @(negedge clock) begin : request_driver
      pixel_req_type next_req;
      logic          busy;
      busy = req_valid && !req_taken;
      req_taken = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!busy) begin
         if (queued_pixels.size() != 0 && !(idling && $urandom_range(0, 99) < 15)) begin
            next_req = queued_pixels.pop_front();
            req_valid    <= 1'b1;
            req_pixel_in <= next_req.pixel;
            req_flush    <= next_req.flush;
            busy = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      sender_idle <= !busy && queued_pixels.size() == 0;
   end

   always @(negedge clock) begin : response_receiver
      rsp_ready <= !idling || $urandom_range(0, 99) >= 15;
   end

   // Responses are checked before the new prediction is queued. A response on the
   // same edge as a request always belongs to an earlier request.
   always @(posedge clock) begin : response_check
      filtered_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (filtered_due.size() == 0) begin
               $error("response with none outstanding: pixel_out %0b valid_out %0b last_out %0b",
                      rsp_pixel_out, rsp_valid_out, rsp_last_out);
               failed = 1'b1;
            end else begin
               want = filtered_due.pop_front();
               check_field("pixel_out", want.pixel_out, rsp_pixel_out);
               check_field("valid_out", want.valid_out, rsp_valid_out);
               check_field("last_out", want.last_out, rsp_last_out);
            end
         end
         if (req_valid && req_ready) begin
            filtered_due.push_back(predict_filtered(req_pixel_in, req_flush));
            req_taken = 1'b1;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Waits until every queued request has gone in and every response has come back.
   // A wait on falling edges first lets the driver notice requests that were only just queued.
   task automatic wait_idle();
      repeat (2) @(negedge clock);
      while (!(sender_idle && filtered_due.size() == 0)) @(negedge clock);
   endtask

   // Only called when the block is idle. The local copy follows the write at once.
   task automatic write_reg(logic [bced_pkg::CSR_IW-1:0] index,
                            logic [bced_pkg::DIM_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         bced_pkg::REG_MODE: mode_sel = value[0];
         bced_pkg::REG_WIDTH: begin
            width_reg = value;
            restart_frame();
         end
         bced_pkg::REG_HEIGHT: begin
            height_reg = value;
            restart_frame();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Queues requests [first, stop) of one frame at the current size: its pixels first,
   // then the drain. With noise, stray flushes are mixed in among the pixels, and some
   // drain requests carry a pixel rather than a flush.
   task automatic queue_frame(int first, int stop, int density, bit noisy);
      int w, h;
      w = clamp_dim(width_reg, bced_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bced_pkg::MAX_HEIGHT);
      @(posedge clock);
      for (int i = first; i < stop; i++) begin
         if (i < w * h) begin
            if (noisy && $urandom_range(0, 99) < 5)
               queued_pixels.push_back(pixel_req_type'{1'($urandom_range(0, 1)), 1'b1});
            queued_pixels.push_back(
               pixel_req_type'{1'($urandom_range(1, 100) <= density), 1'b0});
         end else begin
            queued_pixels.push_back(pixel_req_type'{1'($urandom_range(0, 1)),
                                                    1'(!noisy || $urandom_range(0, 4) != 0)});
         end
      end
   endtask

   // Mostly sizes that keep frames short. Now and then the size is below the minimum
   // and must clamp up.
   function automatic logic [bced_pkg::DIM_W-1:0] pick_dim(int hi);
      if ($urandom_range(0, 9) == 0) return bced_pkg::DIM_W'($urandom_range(0, 2));
      return bced_pkg::DIM_W'($urandom_range(bced_pkg::MIN_DIM, hi));
   endfunction

   initial begin : stimulus
      int w, total, cut, density, counted;
      bit frame_open;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // At the reset size, one pixel and then a flush. The frame is far from done,
      // so the flush is dropped.
      @(posedge clock);
      queued_pixels.push_back(pixel_req_type'{1'b1, 1'b0});
      queued_pixels.push_back(pixel_req_type'{1'b0, 1'b1});
      wait_idle();

      // Erode an all-ones 3 x 3 frame. Its size is written below the minimum, so both
      // dimensions clamp to 3. The zero padding leaves only the centre set. One drain
      // request carries a pixel instead of a flush.
      write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'(bced_pkg::MODE_ERODE));
      write_reg(bced_pkg::REG_WIDTH, bced_pkg::DIM_W'(1));
      write_reg(bced_pkg::REG_HEIGHT, bced_pkg::DIM_W'(0));
      @(posedge clock);
      for (int i = 0; i < 9; i++) queued_pixels.push_back(pixel_req_type'{1'b1, 1'b0});
      queued_pixels.push_back(pixel_req_type'{1'b0, 1'b1});
      queued_pixels.push_back(pixel_req_type'{1'b1, 1'b0});
      queued_pixels.push_back(pixel_req_type'{1'b0, 1'b1});
      queued_pixels.push_back(pixel_req_type'{1'b0, 1'b1});
      wait_idle();

      // Dilate a lone centre pixel in an exact 3 x 3 frame. The result is the plus shape.
      write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'(bced_pkg::MODE_DILATE));
      write_reg(bced_pkg::REG_WIDTH, bced_pkg::DIM_W'(3));
      write_reg(bced_pkg::REG_HEIGHT, bced_pkg::DIM_W'(3));
      @(posedge clock);
      for (int i = 0; i < 9; i++) queued_pixels.push_back(pixel_req_type'{1'(i == 4), 1'b0});
      for (int i = 0; i < 4; i++) queued_pixels.push_back(pixel_req_type'{1'b0, 1'b1});
      wait_idle();

      // A whole frame with no idling on either side, so requests and responses run
      // back to back for its full length.
      idling = 1'b0;
      write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'(bced_pkg::MODE_ERODE));
      write_reg(bced_pkg::REG_WIDTH, bced_pkg::DIM_W'(30));
      write_reg(bced_pkg::REG_HEIGHT, bced_pkg::DIM_W'(6));
      queue_frame(0, 30 * 6 + 30 + 1, 95, 1'b0);
      wait_idle();
      idling = 1'b1;

      // The start of a frame at the widest row. The width is written as all ones and
      // clamps to the maximum. The frame is left open and the next size write restarts it.
      write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'(bced_pkg::MODE_DILATE));
      write_reg(bced_pkg::REG_WIDTH, '1);
      write_reg(bced_pkg::REG_HEIGHT, bced_pkg::DIM_W'(3));
      queue_frame(0, 100, 50, 1'b1);
      wait_idle();

      // The top of the tallest frame, three pixels wide. The height is written as all
      // ones and clamps. This frame is also left open.
      write_reg(bced_pkg::REG_WIDTH, bced_pkg::DIM_W'(3));
      write_reg(bced_pkg::REG_HEIGHT, '1);
      queue_frame(0, 150, 10, 1'b1);

      // Random frames. Most are complete. Some stop part-way, and the next size write
      // restarts them. Others change mode in the middle of the frame.
      counted = 0;
      frame_open = 1'b1;
      while (counted < RANDOM_PIXELS) begin
         wait_idle();
         write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'($urandom_range(0, 1)));
         if (frame_open || $urandom_range(0, 3) == 0) begin
            write_reg(bced_pkg::REG_WIDTH, pick_dim(($urandom_range(0, 7) == 0) ? 40 : 10));
            write_reg(bced_pkg::REG_HEIGHT, pick_dim(8));
            if ($urandom_range(0, 9) == 0)
               write_reg(REG_UNUSED, bced_pkg::DIM_W'($urandom_range(0, 4095)));
            frame_open = 1'b0;
         end
         w = clamp_dim(width_reg, bced_pkg::MAX_WIDTH);
         total = w * clamp_dim(height_reg, bced_pkg::MAX_HEIGHT) + w + 1;
         density = ($urandom_range(0, 2) == 0) ? 90 : $urandom_range(0, 100);
         cut = $urandom_range(1, total - 1);
         case ($urandom_range(0, 9))
            0: begin
               queue_frame(0, cut, density, 1'b1);
               counted += cut;
               frame_open = 1'b1;
            end
            1: begin
               queue_frame(0, cut, density, 1'b1);
               wait_idle();
               write_reg(bced_pkg::REG_MODE, bced_pkg::DIM_W'(!mode_sel));
               queue_frame(cut, total, density, 1'b1);
               counted += total;
            end
            default: begin
               queue_frame(0, total, density, 1'b1);
               counted += total;
            end
         endcase
      end

      wait_idle();
      // The response register is a single stage, so any stray response shows before the final check.
      repeat (4) @(posedge clock);
      if (!failed && filtered_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/bced_pkg.sv
rtl/bced_line_mem.sv
rtl/binary_cross_erode_dilate.sv
tb/tb_binary_cross_erode_dilate.sv
